// ===== rtl/core/qbb_pkg.sv =====
// Shared types and constants of the quoted bracket balance checker.
package qbb_pkg;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_OBRACE = 8'h7B;
  localparam logic [7:0] CH_CBRACE = 8'h7D;
  localparam logic [7:0] CH_OBRACK = 8'h5B;
  localparam logic [7:0] CH_CBRACK = 8'h5D;

  typedef enum logic [2:0] {
    FAULT_NONE     = 3'd0,
    FAULT_STRAY    = 3'd1,
    FAULT_MISMATCH = 3'd2,
    FAULT_UNCLOSED = 3'd3,
    FAULT_OVERFLOW = 3'd4
  } fault_e;

  typedef enum logic [1:0] {
    OP_NONE = 2'd0,
    OP_PUSH = 2'd1,
    OP_POP  = 2'd2
  } op_e;

  // One classified request as it travels from the front to the back.
  typedef struct packed {
    op_e  op;
    logic is_brace;
    logic is_final;
  } entry_t;

  // Queue handshake between front and back.
  typedef struct packed {
    logic   push;
    entry_t entry;
  } q_wr_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } q_rd_t;

endpackage

// ===== rtl/core/qbb_in_if.sv =====
// Input channel: at most one document byte per request.
interface qbb_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       is_final;
  logic       byte_present;

  modport source (output valid, text_byte, is_final, byte_present, input ready);
  modport sink (input valid, text_byte, is_final, byte_present, output ready);
endinterface

// ===== rtl/core/qbb_out_if.sv =====
// Output channel: one verdict per document.
interface qbb_out_if;
  logic       valid;
  logic       ready;
  logic       balanced;
  logic [2:0] fault_kind;

  modport source (output valid, balanced, fault_kind, input ready);
  modport sink (input valid, balanced, fault_kind, output ready);
endinterface

// ===== rtl/core/qbb_ram.sv =====
// Generic single write port RAM with registered read.
module qbb_ram #(
  parameter int Width = 1,
  parameter int Depth = 64,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/core/qbb_front.sv =====
// Front end: accepts bytes, tracks the string flag and classifies brackets.
module qbb_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  qbb_in_if.sink        in_ch,
  input  logic          q_full_i,
  output qbb_pkg::q_wr_t q_wr_o
);

  logic outside_q, outside_d;
  logic take, is_quote;
  qbb_pkg::entry_t entry;

  assign in_ch.ready = !q_full_i;
  assign take        = in_ch.valid && in_ch.ready;
  assign is_quote    = in_ch.byte_present && (in_ch.text_byte == qbb_pkg::CH_QUOTE);

  always_comb begin
    entry.op       = qbb_pkg::OP_NONE;
    entry.is_brace = 1'b0;
    entry.is_final = in_ch.is_final;
    if (in_ch.byte_present && outside_q) begin
      unique case (in_ch.text_byte)
        qbb_pkg::CH_OBRACE: begin
          entry.op       = qbb_pkg::OP_PUSH;
          entry.is_brace = 1'b1;
        end
        qbb_pkg::CH_OBRACK: entry.op = qbb_pkg::OP_PUSH;
        qbb_pkg::CH_CBRACE: begin
          entry.op       = qbb_pkg::OP_POP;
          entry.is_brace = 1'b1;
        end
        qbb_pkg::CH_CBRACK: entry.op = qbb_pkg::OP_POP;
        default: entry.op = qbb_pkg::OP_NONE;
      endcase
    end
  end

  // The flag may run on past a latched fault; nothing reads it until the
  // document ends, and the end puts it back to outside.
  always_comb begin
    outside_d = outside_q;
    if (take && is_quote) begin
      outside_d = !outside_q;
    end
    if (take && in_ch.is_final) begin
      outside_d = 1'b1;
    end
  end

  // Bytes that neither push nor pop and are not final are dropped here.
  assign q_wr_o.push  = take && ((entry.op != qbb_pkg::OP_NONE) || in_ch.is_final);
  assign q_wr_o.entry = entry;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outside_q <= 1'b1;
    end else begin
      outside_q <= outside_d;
    end
  end

endmodule

// ===== rtl/core/qbb_queue.sv =====
// Two-entry queue between front and back.
module qbb_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  qbb_pkg::q_wr_t q_wr_i,
  output logic           full_o,
  output qbb_pkg::q_rd_t q_rd_o,
  input  logic           pop_i
);

  localparam int Entries = 2;

  qbb_pkg::entry_t slot_q [Entries];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       do_push, do_pop;

  assign full_o       = (count_q == 2'(Entries));
  assign q_rd_o.valid = (count_q != 2'd0);
  assign q_rd_o.entry = slot_q[rd_ptr_q];
  assign do_push      = q_wr_i.push && !full_o;
  assign do_pop       = pop_i && q_rd_o.valid;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= q_wr_i.entry;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      count_q <= count_q + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

// ===== rtl/core/qbb_back.sv =====
// Back end: bracket stack, fault latch and the verdict register.
module qbb_back #(
  parameter int STACK_DEPTH = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  qbb_pkg::q_rd_t q_rd_i,
  output logic           pop_o,
  qbb_out_if.source      out_ch
);

  localparam int AddrW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int LvlW  = $clog2(STACK_DEPTH + 1);
  localparam logic [LvlW-1:0] FullLvl = LvlW'(STACK_DEPTH);

  logic [LvlW-1:0] level_q, level_d, raddr_lvl;
  qbb_pkg::fault_e fault_q, fault_d, verdict;
  logic            byp_q, byp_d, byp_bit_q, byp_bit_d;
  logic            out_valid_q, out_valid_d;
  logic            balanced_q, balanced_d;
  qbb_pkg::fault_e out_fault_q, out_fault_d;
  logic            we, rd_bit, top_bit, slot_free, take;
  qbb_pkg::entry_t e;

  assign e         = q_rd_i.entry;
  assign slot_free = !out_valid_q || out_ch.ready;
  assign take      = q_rd_i.valid && (!e.is_final || slot_free);
  assign pop_o     = take;

  // The RAM read is registered; right after a push its output is stale,
  // so the pushed bit is served from a bypass flop.
  assign top_bit   = byp_q ? byp_bit_q : rd_bit;

  always_comb begin
    level_d     = level_q;
    fault_d     = fault_q;
    byp_d       = 1'b0;
    byp_bit_d   = byp_bit_q;
    we          = 1'b0;
    out_valid_d = out_valid_q && !out_ch.ready;
    balanced_d  = balanced_q;
    out_fault_d = out_fault_q;
    verdict     = qbb_pkg::FAULT_NONE;
    if (take) begin
      if (fault_q == qbb_pkg::FAULT_NONE) begin
        unique case (e.op)
          qbb_pkg::OP_PUSH: begin
            if (level_q == FullLvl) begin
              fault_d = qbb_pkg::FAULT_OVERFLOW;
            end else begin
              we        = 1'b1;
              level_d   = level_q + LvlW'(1);
              byp_d     = 1'b1;
              byp_bit_d = e.is_brace;
            end
          end
          qbb_pkg::OP_POP: begin
            if (level_q == '0) begin
              fault_d = qbb_pkg::FAULT_STRAY;
            end else begin
              level_d = level_q - LvlW'(1);
              if (top_bit != e.is_brace) begin
                fault_d = qbb_pkg::FAULT_MISMATCH;
              end
            end
          end
          default: ;
        endcase
      end
      if (e.is_final) begin
        if (fault_d != qbb_pkg::FAULT_NONE) begin
          verdict = fault_d;
        end else if (level_d != '0) begin
          verdict = qbb_pkg::FAULT_UNCLOSED;
        end
        out_valid_d = 1'b1;
        balanced_d  = (verdict == qbb_pkg::FAULT_NONE);
        out_fault_d = verdict;
        level_d     = '0;
        fault_d     = qbb_pkg::FAULT_NONE;
        byp_d       = 1'b0;
      end
    end
  end

  // Always prefetch the entry that will be on top next cycle.
  assign raddr_lvl = level_d - LvlW'(1);

  qbb_ram #(
    .Width (1),
    .Depth (STACK_DEPTH)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (level_q[AddrW-1:0]),
    .wdata_i (e.is_brace),
    .raddr_i (raddr_lvl[AddrW-1:0]),
    .rdata_o (rd_bit)
  );

  always_ff @(posedge clk_i) begin
    byp_bit_q   <= byp_bit_d;
    balanced_q  <= balanced_d;
    out_fault_q <= out_fault_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q     <= '0;
      fault_q     <= qbb_pkg::FAULT_NONE;
      byp_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      level_q     <= level_d;
      fault_q     <= fault_d;
      byp_q       <= byp_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_ch.valid      = out_valid_q;
  assign out_ch.balanced   = balanced_q;
  assign out_ch.fault_kind = out_fault_q;

endmodule

// ===== rtl/core/quoted_bracket_balance_checker.sv =====
// Top level of the quoted bracket balance checker.
// Takes one document byte per cycle, with no gaps between documents, as
// long as a final request does not wait on a held verdict. A double
// quote toggles the in-string flag (escaped or not); outside strings,
// braces and brackets are pushed to and popped from a one-bit-wide stack
// of STACK_DEPTH entries kept in a RAM, and the first fault is latched.
// The front classifies each byte in the cycle it is accepted and hands it
// through a two-entry queue to the back, which does one push or pop per
// cycle unless a final request waits for the output register; that stack
// update, with a bypassed top of stack around the registered RAM read,
// sets the rate. The verdict for a document is held in an output
// register that lets the next document stream in while it waits.
// No clearing pass is needed after reset.
module quoted_bracket_balance_checker #(
  parameter int STACK_DEPTH = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  qbb_in_if.sink    in_ch,
  qbb_out_if.source out_ch
);

  qbb_pkg::q_wr_t q_wr;
  qbb_pkg::q_rd_t q_rd;
  logic           q_full, q_pop;

  qbb_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_ch    (in_ch),
    .q_full_i (q_full),
    .q_wr_o   (q_wr)
  );

  qbb_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .q_wr_i (q_wr),
    .full_o (q_full),
    .q_rd_o (q_rd),
    .pop_i  (q_pop)
  );

  qbb_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .q_rd_i (q_rd),
    .pop_o  (q_pop),
    .out_ch (out_ch)
  );

endmodule
